>>> design/idts_pkg.sv
// ----------------------------------------------------------------------------
// idts_pkg
// Shared types and constants of the idle drift tare scheduler.
// ----------------------------------------------------------------------------
package idts_pkg;

    localparam int IDTS_MAX_SENSORS = 4;
    localparam int TIME_W           = 32;
    localparam int ACTIVE_W         = 3;
    localparam int CFG_ADDR_W       = 2;
    localparam int CFG_DATA_W       = 32;

    // Register indexes on the configuration port
    localparam logic [CFG_ADDR_W-1:0] REG_ACTIVE_SENSORS = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_UPDATE_INTERVAL = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_IDLE_TIME      = 2'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_COOLDOWN       = 2'd3;

    // Reset values of the registers
    localparam logic [ACTIVE_W-1:0] RST_ACTIVE_SENSORS  = 3'd4;
    localparam logic [TIME_W-1:0]   RST_UPDATE_INTERVAL = 32'd100;
    localparam logic [TIME_W-1:0]   RST_IDLE_TIME       = 32'd5000;
    localparam logic [TIME_W-1:0]   RST_COOLDOWN        = 32'd10000;

    // Operation codes carried on s_tuser
    localparam logic FUNC_INIT   = 1'b0;
    localparam logic FUNC_UPDATE = 1'b1;

    typedef struct packed {
        logic [ACTIVE_W-1:0] active_sensors;
        logic [TIME_W-1:0]   update_interval;
        logic [TIME_W-1:0]   idle_time;
        logic [TIME_W-1:0]   cooldown;
    } cfg_t;

    // One tracker entry as held in the state memory
    typedef struct packed {
        logic [TIME_W-1:0] tare_stamp;
        logic              idle_flag;
        logic [TIME_W-1:0] activity_stamp;
        logic [TIME_W-1:0] update_stamp;
    } entry_t;

    typedef enum logic {
        ST_IDLE,
        ST_RUN
    } state_t;

endpackage

>>> design/idts_ram.sv
// ----------------------------------------------------------------------------
// idts_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module idts_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              aclk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

>>> design/idts_walker.sv
// ----------------------------------------------------------------------------
// idts_walker
// Walks the tracked sensors of one word: reads each state memory entry,
// updates and writes it back and, for updates, loads the result register.
// ----------------------------------------------------------------------------
module idts_walker import idts_pkg::*; #(
    parameter int MAX_SENSORS = IDTS_MAX_SENSORS,
    parameter int IDX_W = (MAX_SENSORS > 1) ? $clog2(MAX_SENSORS) : 1
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  cfg_t              cfg,
    // input word
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic              s_func,
    input  logic [TIME_W-1:0] s_now,
    input  logic              s_unloaded,
    // result word
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [1:0]        m_sensor_index,
    output logic              m_is_idle,
    output logic              m_tare_trigger,
    output logic              m_last,
    // state memory
    output logic              ram_rd_en,
    output logic [IDX_W-1:0]  ram_rd_addr,
    input  entry_t            ram_rd_data,
    output logic              ram_wr_en,
    output logic [IDX_W-1:0]  ram_wr_addr,
    output entry_t            ram_wr_data
);

    localparam int CNT_W = $clog2(MAX_SENSORS + 1);

    state_t state_reg, state_next;

    logic              func_reg;
    logic [TIME_W-1:0] now_reg;
    logic              unloaded_reg;
    logic [CNT_W-1:0]  n_reg, n_next;
    logic [CNT_W-1:0]  issue_cnt_reg, issue_cnt_next;
    logic              proc_valid_reg, proc_valid_next;
    logic [IDX_W-1:0]  proc_idx_reg;
    logic [MAX_SENSORS-1:0] entry_valid_reg;

    logic              m_valid_reg, m_valid_next;
    logic [1:0]        m_index_reg;
    logic              m_idle_reg, m_tare_reg, m_last_reg;

    logic              accept;
    logic              proc_fire;
    logic              proc_last;
    entry_t            cur;
    entry_t            upd;
    logic              tare;
    logic              due, long_quiet, cool_done;
    logic [TIME_W-1:0] since_upd, quiet, since_tare;
    logic [IDX_W+1:0]  idx_ext;

    assign accept = s_tvalid && s_tready;

    // saturate the active count
    always_comb begin
        if (32'(cfg.active_sensors) > 32'(MAX_SENSORS)) begin
            n_next = CNT_W'(MAX_SENSORS);
        end else begin
            n_next = CNT_W'(cfg.active_sensors);
        end
    end

    // never-written entries read as zero
    assign cur = entry_valid_reg[proc_idx_reg] ? ram_rd_data : '0;

    assign proc_last = ((CNT_W'(proc_idx_reg) + CNT_W'(1)) == n_reg);
    assign proc_fire = proc_valid_reg &&
                       ((func_reg == FUNC_INIT) || !m_valid_reg || m_tready);

    // per-sensor tracking update
    always_comb begin
        since_upd  = now_reg - cur.update_stamp;
        quiet      = now_reg - cur.activity_stamp;
        since_tare = now_reg - cur.tare_stamp;
        due        = since_upd >= cfg.update_interval;
        long_quiet = quiet > cfg.idle_time;
        cool_done  = since_tare > cfg.cooldown;
        upd        = cur;
        tare       = 1'b0;
        if (func_reg == FUNC_INIT) begin
            upd.activity_stamp = now_reg;
            upd.update_stamp   = now_reg;
            upd.idle_flag      = 1'b0;
        end else if (due) begin
            upd.update_stamp = now_reg;
            if (unloaded_reg) begin
                upd.idle_flag = cur.idle_flag || long_quiet;
                if (long_quiet && cool_done) begin
                    tare           = 1'b1;
                    upd.tare_stamp = now_reg;
                end
            end else begin
                upd.idle_flag      = 1'b0;
                upd.activity_stamp = now_reg;
            end
        end
    end

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept && (n_next != '0)) begin
                    state_next = ST_RUN;
                end
            end
            ST_RUN: begin
                if (proc_fire && proc_last) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // FSM outputs
    always_comb begin
        s_tready  = 1'b0;
        ram_rd_en = 1'b0;
        unique case (state_reg)
            ST_IDLE: s_tready = 1'b1;
            ST_RUN: begin
                ram_rd_en = (issue_cnt_reg < n_reg) && (!proc_valid_reg || proc_fire);
            end
            default: s_tready = 1'b0;
        endcase
    end

    assign ram_rd_addr = issue_cnt_reg[IDX_W-1:0];
    assign ram_wr_en   = proc_fire;
    assign ram_wr_addr = proc_idx_reg;
    assign ram_wr_data = upd;

    always_comb begin
        issue_cnt_next = issue_cnt_reg;
        if (accept) begin
            issue_cnt_next = '0;
        end else if (ram_rd_en) begin
            issue_cnt_next = issue_cnt_reg + CNT_W'(1);
        end
    end

    always_comb begin
        proc_valid_next = proc_valid_reg;
        if (ram_rd_en) begin
            proc_valid_next = 1'b1;
        end else if (proc_fire) begin
            proc_valid_next = 1'b0;
        end
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (proc_fire && (func_reg == FUNC_UPDATE)) begin
            m_valid_next = 1'b1;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    assign idx_ext = {2'b00, proc_idx_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_IDLE;
            issue_cnt_reg   <= '0;
            proc_valid_reg  <= 1'b0;
            entry_valid_reg <= '0;
            m_valid_reg     <= 1'b0;
        end else begin
            state_reg      <= state_next;
            issue_cnt_reg  <= issue_cnt_next;
            proc_valid_reg <= proc_valid_next;
            m_valid_reg    <= m_valid_next;
            if (proc_fire) begin
                entry_valid_reg[proc_idx_reg] <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            func_reg     <= s_func;
            now_reg      <= s_now;
            unloaded_reg <= s_unloaded;
            n_reg        <= n_next;
        end
        if (ram_rd_en) begin
            proc_idx_reg <= ram_rd_addr;
        end
        if (proc_fire && (func_reg == FUNC_UPDATE)) begin
            m_index_reg <= idx_ext[1:0];
            m_idle_reg  <= upd.idle_flag;
            m_tare_reg  <= tare;
            m_last_reg  <= proc_last;
        end
    end

    assign m_tvalid       = m_valid_reg;
    assign m_sensor_index = m_index_reg;
    assign m_is_idle      = m_idle_reg;
    assign m_tare_trigger = m_tare_reg;
    assign m_last         = m_last_reg;

    // work in the pipeline only while a word is being walked
    a_proc_in_run: assert property (@(posedge aclk) disable iff (!aresetn)
        proc_valid_reg |-> (state_reg == ST_RUN))
        else $error("entry in flight outside a walk");

    // never read past the tracked sensors
    a_issue_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        ram_rd_en |-> (issue_cnt_reg < n_reg))
        else $error("read beyond tracked sensors");

    // the read of the next entry never hits the entry being written
    a_no_collide: assert property (@(posedge aclk) disable iff (!aresetn)
        (ram_rd_en && ram_wr_en) |-> (ram_rd_addr != ram_wr_addr))
        else $error("read and write of the same entry");

    // the last sensor closes the walk
    a_last_ends: assert property (@(posedge aclk) disable iff (!aresetn)
        (proc_fire && proc_last) |=> (state_reg == ST_IDLE))
        else $error("walk not closed after last sensor");

endmodule

>>> design/idle_drift_tare_scheduler_unit.sv
// ----------------------------------------------------------------------------
// idle_drift_tare_scheduler_unit
// Load cell auto-zero tracking: idle detection and soft tare scheduling.
// ----------------------------------------------------------------------------
// A word on s_ carries an operation (s_tuser: 0 init, 1 update), a wrapping
// millisecond time stamp and a signed load balance. Init restarts every
// tracked sensor at the given time and gives no result. Update visits the
// tracked sensors 0..N-1 (N = active_sensors, capped at MAX_SENSORS) and
// gives one result word per sensor on m_, tlast on the last one; active
// count zero gives none. Per-sensor stamps and the idle flag live in one
// state memory with registered reads; each visit is a read, an update and a
// write back, and the read of the next sensor overlaps the update of the
// current one, so the walk handles one sensor per cycle while m_tready is
// high. s_tready comes back together with the last result (an init word
// walks the same way without results; with active count zero s_tready
// stays high). A stalled receiver holds the walk for as long as it stalls.
// s_tready is high between walks, and a finished result can wait in the
// output register while the next word is taken. After reset every entry
// reads as zero (per-entry valid bits), with no clearing pass.
// Registers are written on cfg_we and must only change between walks.
// ----------------------------------------------------------------------------
module idle_drift_tare_scheduler_unit import idts_pkg::*; #(
    parameter int MAX_SENSORS = IDTS_MAX_SENSORS
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    // configuration write port
    input  logic                  cfg_we,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    // input words
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [63:0]           s_tdata,   // [31:0] now_ms, [63:32] balance
    input  logic                  s_tuser,   // [0] func
    // result words
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [7:0]            m_tdata,   // [1:0] sensor_index, [2] is_idle,
                                             // [3] tare_trigger, [7:4] zero
    output logic                  m_tlast
);

    localparam int IDX_W = (MAX_SENSORS > 1) ? $clog2(MAX_SENSORS) : 1;

    cfg_t cfg_reg;

    logic             ram_rd_en, ram_wr_en;
    logic [IDX_W-1:0] ram_rd_addr, ram_wr_addr;
    entry_t           ram_rd_data, ram_wr_data;

    logic [1:0] m_sensor_index;
    logic       m_is_idle, m_tare_trigger;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.active_sensors  <= RST_ACTIVE_SENSORS;
            cfg_reg.update_interval <= RST_UPDATE_INTERVAL;
            cfg_reg.idle_time       <= RST_IDLE_TIME;
            cfg_reg.cooldown        <= RST_COOLDOWN;
        end else if (cfg_we) begin
            unique case (cfg_addr)
                REG_ACTIVE_SENSORS:  cfg_reg.active_sensors  <= cfg_wdata[ACTIVE_W-1:0];
                REG_UPDATE_INTERVAL: cfg_reg.update_interval <= cfg_wdata[TIME_W-1:0];
                REG_IDLE_TIME:       cfg_reg.idle_time       <= cfg_wdata[TIME_W-1:0];
                REG_COOLDOWN:        cfg_reg.cooldown        <= cfg_wdata[TIME_W-1:0];
                default: ;
            endcase
        end
    end

    idts_walker #(
        .MAX_SENSORS (MAX_SENSORS),
        .IDX_W       (IDX_W)
    ) u_walker (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg            (cfg_reg),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .s_func         (s_tuser),
        .s_now          (s_tdata[31:0]),
        .s_unloaded     (s_tdata[63:32] == 32'd0),   // only zero vs nonzero matters
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_sensor_index (m_sensor_index),
        .m_is_idle      (m_is_idle),
        .m_tare_trigger (m_tare_trigger),
        .m_last         (m_tlast),
        .ram_rd_en      (ram_rd_en),
        .ram_rd_addr    (ram_rd_addr),
        .ram_rd_data    (ram_rd_data),
        .ram_wr_en      (ram_wr_en),
        .ram_wr_addr    (ram_wr_addr),
        .ram_wr_data    (ram_wr_data)
    );

    // tracker state: one entry per sensor
    idts_ram #(
        .WIDTH  ($bits(entry_t)),
        .DEPTH  (MAX_SENSORS),
        .ADDR_W (IDX_W)
    ) u_state_ram (
        .aclk    (aclk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    assign m_tdata = {4'b0000, m_tare_trigger, m_is_idle, m_sensor_index};

endmodule
